// ===== src/dep_pkg.sv =====
// Shared types and constants for the dual encoder position and speed unit.
`timescale 1ns / 1ps

package dep_pkg;

    localparam int RAW_W   = 16;
    localparam int POS_W   = 32;
    localparam int WIN_W   = 8;
    localparam int SCALE_W = 10;
    localparam int PROD_W  = POS_W + SCALE_W;
    localparam int CNT_W   = $clog2(PROD_W);

    localparam logic [SCALE_W-1:0] SPEED_SCALE        = SCALE_W'(1000);
    localparam logic [WIN_W-1:0]   WINDOW_TICKS_RESET = WIN_W'(10);

    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_RIGHT = 2'd1,
        OP_CLEAR = 2'd2
    } t_op;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_LSTART,
        ST_LWAIT,
        ST_RSTART,
        ST_RWAIT,
        ST_RESULT
    } t_seq_state;

    typedef enum logic [1:0] {
        DIV_IDLE,
        DIV_MUL,
        DIV_RUN,
        DIV_FIX
    } t_div_state;

    typedef struct packed {
        logic                    start;
        logic signed [POS_W-1:0] diff;
        logic [WIN_W-1:0]        divisor;
    } t_div_req;

    typedef struct packed {
        logic                    done;
        logic signed [POS_W-1:0] quotient;
    } t_div_rsp;

endpackage

// ===== src/dep_divider.sv =====
// Shared speed unit: scales a position change by 1000 and divides it, one bit a cycle.
`timescale 1ns / 1ps

module dep_divider (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  dep_pkg::t_div_req i_req,
    output dep_pkg::t_div_rsp o_rsp
);
    import dep_pkg::*;

    t_div_state r_state, n_state;

    logic              r_neg;
    logic [POS_W-1:0]  r_mag;
    logic [WIN_W-1:0]  r_div;
    logic [PROD_W-1:0] r_q;
    logic [WIN_W-1:0]  r_rem;
    logic [CNT_W-1:0]  r_cnt;

    logic [POS_W-1:0]  n_mag;
    logic [WIN_W:0]    n_trial;
    logic              n_qbit;
    logic [WIN_W-1:0]  n_rem;
    logic              n_over;
    logic [POS_W-1:0]  n_low;

    // Magnitude of the change; the most negative value maps to 2^31 unsigned.
    assign n_mag = i_req.diff[POS_W-1] ? (~i_req.diff + POS_W'(1)) : i_req.diff;

    // One restoring division step.
    always_comb begin
        n_trial = {r_rem, r_q[PROD_W-1]};
        n_qbit  = (n_trial >= {1'b0, r_div});
        n_rem   = n_qbit ? WIN_W'(n_trial - {1'b0, r_div}) : n_trial[WIN_W-1:0];
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            DIV_IDLE: if (i_req.start) n_state = DIV_MUL;
            DIV_MUL:  n_state = DIV_RUN;
            DIV_RUN:  if (r_cnt == '0) n_state = DIV_FIX;
            DIV_FIX:  n_state = DIV_IDLE;
            default:  n_state = DIV_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= DIV_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            DIV_IDLE: begin
                if (i_req.start) begin
                    r_neg <= i_req.diff[POS_W-1];
                    r_mag <= n_mag;
                    r_div <= i_req.divisor;
                end
            end
            DIV_MUL: begin
                r_q   <= PROD_W'(r_mag) * PROD_W'(SPEED_SCALE);
                r_rem <= '0;
                r_cnt <= CNT_W'(PROD_W - 1);
            end
            DIV_RUN: begin
                r_q   <= {r_q[PROD_W-2:0], n_qbit};
                r_rem <= n_rem;
                r_cnt <= r_cnt - CNT_W'(1);
            end
            default: begin
            end
        endcase
    end

    // Saturation: a positive result tops out at 2^31-1, a negative one at -2^31.
    always_comb begin
        n_over = r_neg ? (r_q > PROD_W'(64'h8000_0000))
                       : (r_q > PROD_W'(64'h7FFF_FFFF));
        n_low  = r_q[POS_W-1:0];
        o_rsp.done = (r_state == DIV_FIX);
        if (n_over) begin
            o_rsp.quotient = r_neg ? {1'b1, {(POS_W-1){1'b0}}} : {1'b0, {(POS_W-1){1'b1}}};
        end else begin
            o_rsp.quotient = r_neg ? (~n_low + POS_W'(1)) : n_low;
        end
    end

endmodule

// ===== src/dual_encoder_position_speed_unit.sv =====
// Top level of the dual encoder position and speed unit: sequencer, state and output stage.
// A tick that closes a speed window makes two passes through the shared divider, left then
// right, before its result is loaded; every other request goes from execution to the result.
// A new request is accepted only once the sequencer is back in idle.
// The divider, one quotient bit per cycle over 42 bits, makes the closing tick the slower case.
// Reset (synchronous, active low) clears positions, snapshots, speeds, the window and
// sets the window length to 10 ticks; no clearing pass is needed.
`timescale 1ns / 1ps

module dual_encoder_position_speed_unit (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // Configuration: window length in ticks.
    input  logic                     i_cfg_we,
    input  logic [dep_pkg::WIN_W-1:0] i_cfg_wdata,
    // Input requests.
    input  logic                     i_s_tvalid,
    output logic                     o_s_tready,
    input  logic [23:0]              i_s_tdata,  // qei_raw [15:0], phase_a [16], phase_b [17], zero
    input  logic [1:0]               i_s_tuser,  // operation [1:0]
    // Results.
    output logic                     o_m_tvalid,
    input  logic                     i_m_tready,
    output logic [127:0]             o_m_tdata,  // left_position, right_position, left_speed,
                                                 // right_speed, 32 bits each from the bottom
    output logic [0:0]               o_m_tuser   // speed_updated [0]
);
    import dep_pkg::*;

    t_seq_state r_state, n_state;

    // Captured request.
    t_op              r_op;
    logic [RAW_W-1:0] r_raw;
    logic             r_pa;
    logic             r_pb;

    // Block state.
    logic [WIN_W-1:0] r_window_ticks;
    logic [RAW_W-1:0] r_prev_raw;
    logic [POS_W-1:0] r_left_total;
    logic [POS_W-1:0] r_right_total;
    logic [POS_W-1:0] r_left_snapshot;
    logic [POS_W-1:0] r_right_snapshot;
    logic [WIN_W-1:0] r_window_count;
    logic [POS_W-1:0] r_left_rate;
    logic [POS_W-1:0] r_right_rate;
    logic             r_updated;

    // Operands held for the divider while a window closes.
    logic [POS_W-1:0] r_left_diff;
    logic [POS_W-1:0] r_right_diff;
    logic [WIN_W-1:0] r_div_count;

    // Output register.
    logic             r_m_valid;
    logic [127:0]     r_m_data;
    logic             r_m_user;

    logic [RAW_W-1:0] n_delta;
    logic [POS_W-1:0] n_left_new;
    logic [WIN_W-1:0] n_win_inc;
    logic             n_close;
    logic             n_out_free;

    t_div_req div_req;
    t_div_rsp div_rsp;

    dep_divider u_divider (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // The left counter wraps at 16 bits, so the wrapped difference is taken as signed and
    // sign-extended into the 32-bit position.
    always_comb begin
        n_delta    = r_raw - r_prev_raw;
        n_left_new = r_left_total + {{(POS_W-RAW_W){n_delta[RAW_W-1]}}, n_delta};
        n_win_inc  = r_window_count + WIN_W'(1);
        if (n_win_inc == '0) begin
            n_win_inc = WIN_W'(1);
        end
        // A window length of zero or one lowered below the count closes on this tick.
        n_close    = (n_win_inc >= r_window_ticks);
        n_out_free = !r_m_valid || i_m_tready;
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:   if (i_s_tvalid) n_state = ST_EXEC;
            ST_EXEC:   n_state = (r_op == OP_TICK && n_close) ? ST_LSTART : ST_RESULT;
            ST_LSTART: n_state = ST_LWAIT;
            ST_LWAIT:  if (div_rsp.done) n_state = ST_RSTART;
            ST_RSTART: n_state = ST_RWAIT;
            ST_RWAIT:  if (div_rsp.done) n_state = ST_RESULT;
            ST_RESULT: if (n_out_free) n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    // Outputs of the sequencer.
    always_comb begin
        o_s_tready      = (r_state == ST_IDLE);
        div_req.start   = (r_state == ST_LSTART) || (r_state == ST_RSTART);
        div_req.diff    = (r_state == ST_LSTART) ? r_left_diff : r_right_diff;
        div_req.divisor = r_div_count;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Configuration register; the user must write it only while the block is idle (not enforced here).
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_ticks <= WINDOW_TICKS_RESET;
        end else if (i_cfg_we) begin
            r_window_ticks <= i_cfg_wdata;
        end
    end

    // Request capture.
    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && i_s_tvalid) begin
            r_op  <= t_op'(i_s_tuser);
            r_raw <= i_s_tdata[RAW_W-1:0];
            r_pa  <= i_s_tdata[RAW_W];
            r_pb  <= i_s_tdata[RAW_W+1];
        end
    end

    // Position, window and speed state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_raw       <= '0;
            r_left_total     <= '0;
            r_right_total    <= '0;
            r_left_snapshot  <= '0;
            r_right_snapshot <= '0;
            r_window_count   <= '0;
            r_left_rate      <= '0;
            r_right_rate     <= '0;
            r_updated        <= 1'b0;
        end else begin
            case (r_state)
                ST_EXEC: begin
                    r_updated <= 1'b0;
                    case (r_op)
                        OP_TICK: begin
                            r_prev_raw   <= r_raw;
                            r_left_total <= n_left_new;
                            if (n_close) begin
                                // Snapshots move on now; the divider works from the held
                                // differences.
                                r_left_diff      <= n_left_new - r_left_snapshot;
                                r_right_diff     <= r_right_total - r_right_snapshot;
                                r_div_count      <= n_win_inc;
                                r_left_snapshot  <= n_left_new;
                                r_right_snapshot <= r_right_total;
                                r_window_count   <= '0;
                                r_updated        <= 1'b1;
                            end else begin
                                r_window_count <= n_win_inc;
                            end
                        end
                        OP_RIGHT: begin
                            // Phases that differ mean a forward step.
                            if (r_pa != r_pb) begin
                                r_right_total <= r_right_total + POS_W'(1);
                            end else begin
                                r_right_total <= r_right_total - POS_W'(1);
                            end
                        end
                        OP_CLEAR: begin
                            r_left_total     <= '0;
                            r_right_total    <= '0;
                            r_left_snapshot  <= '0;
                            r_right_snapshot <= '0;
                            r_left_rate      <= '0;
                            r_right_rate     <= '0;
                            r_window_count   <= '0;
                            r_prev_raw       <= r_raw;
                        end
                        default: begin
                            // The unused code leaves the positions, window and speeds as they are.
                        end
                    endcase
                end
                ST_LWAIT: begin
                    if (div_rsp.done) begin
                        r_left_rate <= div_rsp.quotient;
                    end
                end
                ST_RWAIT: begin
                    if (div_rsp.done) begin
                        r_right_rate <= div_rsp.quotient;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Output register: the result is loaded once the previous one has been taken, so the
    // sequencer returns to idle and can accept the next request while this one waits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (r_state == ST_RESULT && n_out_free) begin
            r_m_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_RESULT && n_out_free) begin
            r_m_data <= {r_right_rate, r_left_rate, r_right_total, r_left_total};
            r_m_user <= r_updated;
        end
    end

    assign o_m_tvalid   = r_m_valid;
    assign o_m_tdata    = r_m_data;
    assign o_m_tuser[0] = r_m_user;

endmodule
